>>> sv/kli_pkg.sv
`default_nettype none
package kli_pkg;

    localparam int FRAMES  = 40;
    localparam int LAYERS  = 8;
    localparam int SCRIPTS = 8;
    localparam int NVAL    = 7;
    localparam int TRACKS  = SCRIPTS * LAYERS;
    localparam int KEYS    = TRACKS * FRAMES;
    localparam int TR_W    = $clog2(TRACKS);
    localparam int KEY_AW  = $clog2(KEYS);
    localparam int CNT_W   = $clog2(FRAMES + 1);

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QTIME  = 2'd2;
    localparam logic [1:0] OP_QFRAC  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_NOKEY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [15:0]                texture;
        logic [NVAL-1:0][31:0]      value;
        logic [31:0]                ktime;
    } key_row_t;

    localparam int ROW_W = $bits(key_row_t);

    typedef struct packed {
        logic        start;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] num;
        logic [31:0] den;
    } lerp_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } lerp_rsp_t;

endpackage
`default_nettype wire

>>> sv/kli_ram.sv
`default_nettype none
module kli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/kli_lerp.sv
`default_nettype none
module kli_lerp
    import kli_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire lerp_req_t req,
    output lerp_rsp_t rsp
);

    localparam logic [1:0] L_IDLE = 2'd0;
    localparam logic [1:0] L_MUL  = 2'd1;
    localparam logic [1:0] L_DIV  = 2'd2;
    localparam logic [1:0] L_FIN  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [4:0]  cnt_reg;
    logic [31:0] a_reg, mag_reg, num_reg, den_reg, rem_reg, low_reg;
    logic        neg_reg;
    logic [32:0] diff;
    logic [31:0] mag;
    logic [63:0] prod;
    logic [32:0] trial;
    logic        ge;

    // magnitude and sign of b - a, the product and the divide trial step
    always_comb
    begin
        diff = {req.b[31], req.b} - {req.a[31], req.a};
        mag  = diff[32] ? 32'(-diff) : diff[31:0];
        prod = 64'(mag_reg) * 64'(num_reg);
        trial = {rem_reg, low_reg[31]};
        ge    = trial >= {1'b0, den_reg};
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            L_IDLE:  if (req.start) state_next = L_MUL;
            L_MUL:   state_next = L_DIV;
            L_DIV:   if (cnt_reg == 5'd31) state_next = L_FIN;
            L_FIN:   state_next = L_IDLE;
            default: state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath: one multiply, then one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    a_reg   <= req.a;
                    neg_reg <= diff[32];
                    mag_reg <= mag;
                    num_reg <= req.num;
                    den_reg <= req.den;
                end
            end
            L_MUL:
            begin
                rem_reg <= prod[63:32];
                low_reg <= prod[31:0];
                cnt_reg <= 5'd0;
            end
            L_DIV:
            begin
                rem_reg <= ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                low_reg <= {low_reg[30:0], ge};
                cnt_reg <= cnt_reg + 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done   = (state_reg == L_FIN);
    assign rsp.result = neg_reg ? (a_reg - low_reg) : (a_reg + low_reg);

endmodule
`default_nettype wire

>>> sv/keyframe_linear_interpolator.sv
`default_nettype none
// Keyframe track store with linear interpolation. One item is handled at a
// time: clear and append go through the key count lookup (and, when the
// track is full, a read of its last key); a query reads the first and last
// keys, then scans up to 40 keys, and a query that lands between two keys
// runs each of the seven values through the shared multiply and bit-serial
// divide unit. Key rows sit in one single-port-read RAM, per-track key counts
// in a small RAM with valid bits, so no clearing pass is needed after reset.
// A finished result waits in an output register while the next item is taken.
module keyframe_linear_interpolator
    import kli_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [2:0]         script_index,
    input  wire logic [2:0]         layer_index,
    input  wire logic signed [31:0] key_time,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_y,
    input  wire logic signed [31:0] origin_z,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic signed [31:0] angle,
    input  wire logic signed [31:0] alpha,
    input  wire logic [15:0]        texture,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      out_origin_x,
    output logic signed [31:0]      out_origin_y,
    output logic signed [31:0]      out_origin_z,
    output logic signed [31:0]      out_scale_x,
    output logic signed [31:0]      out_scale_y,
    output logic signed [31:0]      out_angle,
    output logic signed [31:0]      out_alpha,
    output logic [15:0]             out_texture,
    output logic                    last_frame,
    output logic signed [31:0]      end_time
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CNT   = 4'd1;
    localparam logic [3:0] S_FULL  = 4'd2;
    localparam logic [3:0] S_FIRST = 4'd3;
    localparam logic [3:0] S_LAST  = 4'd4;
    localparam logic [3:0] S_TIME  = 4'd5;
    localparam logic [3:0] S_SCAN  = 4'd6;
    localparam logic [3:0] S_LGO   = 4'd7;
    localparam logic [3:0] S_LWAIT = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]          state_reg, state_next;
    logic                accept;

    // item registers
    logic [1:0]          op_reg;
    logic [2:0]          s_reg, l_reg;
    logic signed [31:0]  ktime_reg;
    key_row_t            in_row_reg;
    logic [TR_W-1:0]     tr_reg;
    logic [KEY_AW-1:0]   base_reg;
    logic [CNT_W-1:0]    n_reg, i_reg;
    logic [2:0]          k_reg;
    logic signed [31:0]  t0_reg, t1_reg, t_reg;
    logic signed [50:0]  prod_reg;
    key_row_t            prev_row_reg, cur_row_reg;
    logic [31:0]         num_reg, den_reg;

    // track bookkeeping
    logic [3:0]          script_count_reg;
    logic [3:0]          layer_count_reg [SCRIPTS];
    logic [TRACKS-1:0]   fvalid_reg;

    // result and output registers
    logic [1:0]              res_status_reg, out_status_reg;
    logic [NVAL-1:0][31:0]   res_value_reg, out_value_reg;
    logic [15:0]             res_tex_reg, out_tex_reg;
    logic                    res_last_reg, out_last_reg;
    logic [31:0]             res_end_reg, out_end_reg;
    logic                    out_valid_reg;

    // memories
    logic                fr_we, fr_re;
    logic [TR_W-1:0]     fr_raddr;
    logic [CNT_W-1:0]    fr_rdata;
    logic                kr_we, kr_re;
    logic [KEY_AW-1:0]   kr_waddr, kr_raddr;
    logic [ROW_W-1:0]    kr_rdata;
    key_row_t            row;

    lerp_req_t           lreq;
    lerp_rsp_t           lrsp;

    logic [CNT_W-1:0]    n_cur;
    logic                missing;
    logic [TR_W-1:0]     tr_in;
    logic [16:0]         fclamp;
    logic signed [50:0]  prod_adj;
    logic signed [34:0]  cand;
    logic signed [31:0]  t_clamped;
    logic                is_match, is_bracket, is_end;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign row      = key_row_t'(kr_rdata);
    assign tr_in    = {script_index, layer_index};

    kli_ram #(.WIDTH(CNT_W), .DEPTH(TRACKS)) u_count_ram (
        .clk   (clk),
        .we    (fr_we),
        .waddr (tr_reg),
        .wdata (CNT_W'(n_cur + 1'b1)),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    kli_ram #(.WIDTH(ROW_W), .DEPTH(KEYS)) u_key_ram (
        .clk   (clk),
        .we    (kr_we),
        .waddr (kr_waddr),
        .wdata (in_row_reg),
        .re    (kr_re),
        .raddr (kr_raddr),
        .rdata (kr_rdata)
    );

    kli_lerp u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lreq),
        .rsp   (lrsp)
    );

    // key count of the addressed track and the missing-track test
    always_comb
    begin
        n_cur   = fvalid_reg[tr_reg] ? fr_rdata : '0;
        missing = ({1'b0, s_reg} >= script_count_reg) ||
                  ({1'b0, l_reg} >= layer_count_reg[s_reg]) ||
                  (n_cur == '0);
    end

    // memory control
    always_comb
    begin
        fr_re    = accept;
        fr_raddr = tr_in;
        fr_we    = 1'b0;
        kr_we    = 1'b0;
        kr_waddr = base_reg + KEY_AW'(n_cur);
        kr_re    = 1'b0;
        kr_raddr = base_reg;
        case (state_reg)
            S_CNT:
            begin
                if (op_reg == OP_APPEND)
                begin
                    if (n_cur >= CNT_W'(FRAMES))
                    begin
                        kr_re    = 1'b1;
                        kr_raddr = base_reg + KEY_AW'(n_cur) - 1'b1;
                    end
                    else
                    begin
                        kr_we = 1'b1;
                        fr_we = 1'b1;
                    end
                end
                else if (op_reg != OP_CLEAR)
                begin
                    kr_re = !missing;
                end
            end
            S_FIRST:
            begin
                kr_re    = 1'b1;
                kr_raddr = base_reg + KEY_AW'(n_reg) - 1'b1;
            end
            S_TIME:
            begin
                kr_re = 1'b1;
            end
            S_SCAN:
            begin
                kr_re    = (i_reg + 1'b1) < n_reg;
                kr_raddr = base_reg + KEY_AW'(i_reg) + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // query time: fraction scaling and clamping to the track span
    always_comb
    begin
        if (ktime_reg < 0)
            fclamp = 17'd0;
        else if (ktime_reg > 32'sd65536)
            fclamp = 17'd65536;
        else
            fclamp = ktime_reg[16:0];
        prod_adj = prod_reg + ((prod_reg < 0) ? 51'sd65535 : 51'sd0);
        if (op_reg == OP_QFRAC)
            cand = 35'(t0_reg) + 35'(prod_adj >>> 16);
        else
            cand = 35'(ktime_reg);
        if (cand > 35'(t1_reg))
            t_clamped = t1_reg;
        else if (cand < 35'(t0_reg))
            t_clamped = t0_reg;
        else
            t_clamped = cand[31:0];
    end

    // scan tests: bracket against the previous key, then match this key
    always_comb
    begin
        is_bracket = (i_reg != '0) && (t_reg > $signed(prev_row_reg.ktime)) &&
                     (t_reg < $signed(row.ktime));
        is_match   = ($signed(row.ktime) == t_reg);
        is_end     = (i_reg == n_reg - 1'b1);
    end

    // interpolation request
    always_comb
    begin
        lreq.start = (state_reg == S_LGO);
        lreq.a     = prev_row_reg.value[k_reg];
        lreq.b     = cur_row_reg.value[k_reg];
        lreq.num   = num_reg;
        lreq.den   = den_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_CNT;
            S_CNT:
            begin
                case (op_reg)
                    OP_CLEAR:  state_next = S_DONE;
                    OP_APPEND: state_next = (n_cur >= CNT_W'(FRAMES)) ? S_FULL : S_DONE;
                    default:   state_next = missing ? S_DONE : S_FIRST;
                endcase
            end
            S_FULL:  state_next = S_DONE;
            S_FIRST: state_next = S_LAST;
            S_LAST:  state_next = S_TIME;
            S_TIME:  state_next = S_SCAN;
            S_SCAN:
            begin
                if (is_bracket)
                    state_next = S_LGO;
                else if (is_match || is_end)
                    state_next = S_DONE;
            end
            S_LGO:   state_next = S_LWAIT;
            S_LWAIT: if (lrsp.done && k_reg == 3'(NVAL - 1)) state_next = S_DONE;
                     else if (lrsp.done) state_next = S_LGO;
            S_DONE:  if (!out_valid_reg || out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            script_count_reg <= '0;
            fvalid_reg       <= '0;
            out_valid_reg    <= 1'b0;
            for (int j = 0; j < SCRIPTS; j++)
                layer_count_reg[j] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CNT && op_reg == OP_CLEAR)
            begin
                script_count_reg <= '0;
                fvalid_reg       <= '0;
                for (int j = 0; j < SCRIPTS; j++)
                    layer_count_reg[j] <= '0;
            end
            if (fr_we)
            begin
                fvalid_reg[tr_reg] <= 1'b1;
                if (script_count_reg < {1'b0, s_reg} + 4'd1)
                    script_count_reg <= {1'b0, s_reg} + 4'd1;
                if (layer_count_reg[s_reg] < {1'b0, l_reg} + 4'd1)
                    layer_count_reg[s_reg] <= {1'b0, l_reg} + 4'd1;
            end
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_reg             <= opcode;
                    s_reg              <= script_index;
                    l_reg              <= layer_index;
                    ktime_reg          <= key_time;
                    tr_reg             <= tr_in;
                    base_reg           <= KEY_AW'(tr_in) * KEY_AW'(FRAMES);
                    in_row_reg.ktime   <= key_time;
                    in_row_reg.value   <= {alpha, angle, scale_y, scale_x,
                                           origin_z, origin_y, origin_x};
                    in_row_reg.texture <= texture;
                    res_status_reg     <= ST_OK;
                    res_value_reg      <= '0;
                    res_tex_reg        <= '0;
                    res_last_reg       <= 1'b0;
                    res_end_reg        <= '0;
                end
            end
            S_CNT:
            begin
                n_reg <= n_cur;
                if (op_reg == OP_APPEND)
                begin
                    if (n_cur >= CNT_W'(FRAMES))
                        res_status_reg <= ST_FULL;
                    else
                        res_end_reg <= in_row_reg.ktime;
                end
                else if (op_reg != OP_CLEAR && missing)
                begin
                    res_status_reg <= ST_MISSING;
                end
            end
            S_FULL:
            begin
                res_end_reg <= row.ktime;
            end
            S_FIRST:
            begin
                t0_reg <= $signed(row.ktime);
            end
            S_LAST:
            begin
                t1_reg      <= $signed(row.ktime);
                res_end_reg <= row.ktime;
                prod_reg    <= 51'((33'($signed(row.ktime)) - 33'(t0_reg)) *
                                   $signed({1'b0, fclamp}));
            end
            S_TIME:
            begin
                t_reg <= t_clamped;
                i_reg <= '0;
            end
            S_SCAN:
            begin
                i_reg <= i_reg + 1'b1;
                if (is_bracket)
                begin
                    cur_row_reg  <= row;
                    num_reg      <= 32'(t_reg - $signed(prev_row_reg.ktime));
                    den_reg      <= 32'($signed(row.ktime) - $signed(prev_row_reg.ktime));
                    res_tex_reg  <= prev_row_reg.texture;
                    k_reg        <= '0;
                end
                else
                begin
                    prev_row_reg <= row;
                    if (is_match)
                    begin
                        res_value_reg <= row.value;
                        res_tex_reg   <= row.texture;
                        res_last_reg  <= is_end;
                    end
                    else if (is_end)
                    begin
                        res_status_reg <= ST_NOKEY;
                    end
                end
            end
            S_LWAIT:
            begin
                if (lrsp.done)
                begin
                    res_value_reg[k_reg] <= lrsp.result;
                    k_reg                <= k_reg + 3'd1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_status_reg <= res_status_reg;
                    out_value_reg  <= res_value_reg;
                    out_tex_reg    <= res_tex_reg;
                    out_last_reg   <= res_last_reg;
                    out_end_reg    <= res_end_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_origin_x = out_value_reg[0];
    assign out_origin_y = out_value_reg[1];
    assign out_origin_z = out_value_reg[2];
    assign out_scale_x  = out_value_reg[3];
    assign out_scale_y  = out_value_reg[4];
    assign out_angle    = out_value_reg[5];
    assign out_alpha    = out_value_reg[6];
    assign out_texture  = out_tex_reg;
    assign last_frame   = out_last_reg;
    assign end_time     = out_end_reg;

endmodule
`default_nettype wire

>>> sv/kli_checker.sv
`default_nettype none
module kli_checker
    import kli_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [1:0]         status,
    input wire logic               last_frame,
    input wire logic signed [31:0] end_time,
    input wire logic signed [31:0] out_origin_x
);

    // a stalled item stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled item keeps its payload
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(status) && $stable(end_time) &&
                                    $stable(out_origin_x))
        else $error("result payload changed while stalled");

    // a missing track reports nothing else
    a_missing: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_MISSING |-> end_time == 0 && !last_frame &&
                                              out_origin_x == 0)
        else $error("missing track with nonzero fields");

    // last key flag only on a good query
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_frame |-> status == ST_OK)
        else $error("last frame flag with error status");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (.*);
`default_nettype wire

>>> tb/kli_checker.sv
`timescale 1ns / 1ps
module kli_monitor
    import kli_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic [1:0]         opcode,
    input  wire logic [2:0]         script_index,
    input  wire logic [2:0]         layer_index,
    input  wire logic signed [31:0] key_time,
    input  wire logic signed [31:0] origin_x,
    input  wire logic signed [31:0] origin_y,
    input  wire logic signed [31:0] origin_z,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic signed [31:0] angle,
    input  wire logic signed [31:0] alpha,
    input  wire logic [15:0]        texture,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic [1:0]         status,
    input  wire logic signed [31:0] out_origin_x,
    input  wire logic signed [31:0] out_origin_y,
    input  wire logic signed [31:0] out_origin_z,
    input  wire logic signed [31:0] out_scale_x,
    input  wire logic signed [31:0] out_scale_y,
    input  wire logic signed [31:0] out_angle,
    input  wire logic signed [31:0] out_alpha,
    input  wire logic [15:0]        out_texture,
    input  wire logic               last_frame,
    input  wire logic signed [31:0] end_time,
    output int                      mismatches,
    output int                      pending
);

    typedef struct packed {
        logic [1:0]            st;
        logic [NVAL-1:0][31:0] v;
        logic [15:0]           tex;
        logic                  last;
        logic [31:0]           endt;
    } frame_res_t;

    // shadow copy of the track store
    int unsigned           n_scripts;
    int unsigned           n_layers [SCRIPTS];
    int unsigned           n_keys   [TRACKS];
    logic [31:0]           key_t    [TRACKS][FRAMES];
    logic [NVAL-1:0][31:0] key_v    [TRACKS][FRAMES];
    logic [15:0]           key_tex  [TRACKS][FRAMES];

    frame_res_t frames_due[$];

    string val_name [NVAL] = '{"origin_x", "origin_y", "origin_z", "scale_x",
                               "scale_y", "angle", "alpha"};

    // a + trunc((b - a) * num / den), wide enough for any span
    function automatic logic [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
                                          longint unsigned num, longint unsigned den);
        longint     d;
        logic [127:0] mag;
        logic [127:0] q;
        d   = longint'(b) - longint'(a);
        mag = (d < 0) ? 128'(-d) : 128'(d);
        q   = (mag * 128'(num)) / 128'(den);
        return (d < 0) ? a - q[31:0] : a + q[31:0];
    endfunction

    task automatic report_miss(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // work out the result of one accepted item and update the shadow store
    task automatic predict_frame();
        frame_res_t r;
        int unsigned tr, n, i;
        longint t0, t1, t, ta, tb;
        logic [NVAL-1:0][31:0] vin;
        bit found;
        r   = '0;
        vin = {alpha, angle, scale_y, scale_x, origin_z, origin_y, origin_x};
        tr  = script_index * LAYERS + layer_index;
        case (opcode)
            OP_CLEAR:
            begin
                n_scripts = 0;
                foreach (n_layers[k]) n_layers[k] = 0;
                foreach (n_keys[k]) n_keys[k] = 0;
            end
            OP_APPEND:
            begin
                n = n_keys[tr];
                if (n >= FRAMES)
                begin
                    r.st   = ST_FULL;
                    r.endt = key_t[tr][n-1];
                end
                else
                begin
                    key_t[tr][n]   = key_time;
                    key_v[tr][n]   = vin;
                    key_tex[tr][n] = texture;
                    n_keys[tr]     = n + 1;
                    if (n_scripts < script_index + 1) n_scripts = script_index + 1;
                    if (n_layers[script_index] < layer_index + 1)
                        n_layers[script_index] = layer_index + 1;
                    r.endt = key_time;
                end
            end
            default:
            begin
                n = n_keys[tr];
                if (script_index >= n_scripts || layer_index >= n_layers[script_index] ||
                    n == 0)
                    r.st = ST_MISSING;
                else
                begin
                    t0     = longint'($signed(key_t[tr][0]));
                    t1     = longint'($signed(key_t[tr][n-1]));
                    r.endt = key_t[tr][n-1];
                    t      = longint'(key_time);
                    if (opcode == OP_QFRAC)
                    begin
                        if (t < 0) t = 0;
                        if (t > 65536) t = 65536;
                        t = t0 + ((t1 - t0) * t) / 65536;
                    end
                    if (t > t1) t = t1;
                    else if (t < t0) t = t0;
                    r.st  = ST_NOKEY;
                    found = 0;
                    // first exact key or bracketing pair met in scan order wins
                    for (i = 0; i < n && !found; i++)
                    begin
                        ta = longint'($signed(key_t[tr][i]));
                        if (ta == t)
                        begin
                            r.st   = ST_OK;
                            r.v    = key_v[tr][i];
                            r.tex  = key_tex[tr][i];
                            r.last = (i == n - 1);
                            found  = 1;
                        end
                        else if (i + 1 < n)
                        begin
                            tb = longint'($signed(key_t[tr][i+1]));
                            if (t > ta && t < tb)
                            begin
                                for (int k = 0; k < NVAL; k++)
                                    r.v[k] = blend(key_v[tr][i][k], key_v[tr][i+1][k],
                                                   t - ta, tb - ta);
                                r.st  = ST_OK;
                                r.tex = key_tex[tr][i];
                                found = 1;
                            end
                        end
                    end
                end
            end
        endcase
        frames_due.push_back(r);
    endtask

    task automatic compare_frame();
        frame_res_t w;
        logic [NVAL-1:0][31:0] got;
        got = {out_alpha, out_angle, out_scale_y, out_scale_x,
               out_origin_z, out_origin_y, out_origin_x};
        if (frames_due.size() == 0)
        begin
            report_miss("unexpected item, status", status, 'x);
            return;
        end
        w = frames_due.pop_front();
        if (status !== w.st) report_miss("status", status, w.st);
        for (int k = 0; k < NVAL; k++)
            if (got[k] !== w.v[k]) report_miss(val_name[k], got[k], w.v[k]);
        if (out_texture !== w.tex) report_miss("texture", out_texture, w.tex);
        if (last_frame !== w.last) report_miss("last_frame", last_frame, w.last);
        if (end_time !== w.endt) report_miss("end_time", end_time, w.endt);
    endtask

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mismatches = 0;
            n_scripts  = 0;
            foreach (n_layers[k]) n_layers[k] = 0;
            foreach (n_keys[k]) n_keys[k] = 0;
            frames_due.delete();
        end
        else
        begin
            if (in_valid && in_ready) predict_frame();
            if (out_valid && out_ready) compare_frame();
        end
        pending = frames_due.size();
    end

endmodule

>>> tb/tb_keyframe_linear_interpolator.sv
`timescale 1ns / 1ps
module tb_keyframe_linear_interpolator;
    import kli_pkg::*;

    localparam int IDLE_LIMIT = 6000;
    localparam int N_RANDOM   = 880;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = OP_CLEAR;
    logic [2:0]         script_index = '0;
    logic [2:0]         layer_index = '0;
    logic signed [31:0] key_time = '0;
    logic signed [31:0] origin_x = '0;
    logic signed [31:0] origin_y = '0;
    logic signed [31:0] origin_z = '0;
    logic signed [31:0] scale_x = '0;
    logic signed [31:0] scale_y = '0;
    logic signed [31:0] angle = '0;
    logic signed [31:0] alpha = '0;
    logic [15:0]        texture = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] out_origin_x, out_origin_y, out_origin_z;
    logic signed [31:0] out_scale_x, out_scale_y, out_angle, out_alpha;
    logic [15:0]        out_texture;
    logic               last_frame;
    logic signed [31:0] end_time;
    int                 mismatches;
    int                 pending;

    // stimulus-side view of each track, only to aim times
    int     keys_in  [TRACKS];
    longint first_t  [TRACKS];
    longint last_t   [TRACKS];

    bit tx_quiet = 0;
    bit rx_quiet = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    always #5 clk = ~clk;

    keyframe_linear_interpolator dut (.*);

    kli_monitor u_monitor (.*);

    // receiver: random stalls plus one long hold-off to back the block up
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_done <= 1;
            hold_left <= 400;
        end
        else
        begin
            if ($urandom_range(0, 99) == 0) rx_quiet <= ~rx_quiet;
            if (rx_quiet)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 149) == 0)
            begin
                out_ready <= 1'b0;
                hold_left <= $urandom_range(10, 40);
            end
            else
                out_ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("keyframe_linear_interpolator: mismatch");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic [1:0] op, logic [2:0] s, logic [2:0] l,
                             logic [31:0] t, logic [NVAL-1:0][31:0] v, logic [15:0] tex);
        int gap;
        int tr;
        tr = s * LAYERS + l;
        in_valid     <= 1'b1;
        opcode       <= op;
        script_index <= s;
        layer_index  <= l;
        key_time     <= t;
        origin_x     <= v[0];
        origin_y     <= v[1];
        origin_z     <= v[2];
        scale_x      <= v[3];
        scale_y      <= v[4];
        angle        <= v[5];
        alpha        <= v[6];
        texture      <= tex;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // track bookkeeping for aiming later times
        if (op == OP_CLEAR)
            foreach (keys_in[k]) keys_in[k] = 0;
        else if (op == OP_APPEND && keys_in[tr] < FRAMES)
        begin
            if (keys_in[tr] == 0) first_t[tr] = longint'($signed(t));
            last_t[tr] = longint'($signed(t));
            keys_in[tr]++;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [NVAL-1:0][31:0] rand_vals();
        logic [NVAL-1:0][31:0] v;
        for (int k = 0; k < NVAL; k++)
            v[k] = ($urandom_range(0, 3) == 0) ? 32'(int'($urandom_range(0, 200000)) - 100000)
                                               : $urandom;
        return v;
    endfunction

    function automatic logic [2:0] pick_index();
        return ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
    endfunction

    task automatic random_item();
        int r, tr;
        logic [2:0] s, l;
        logic [31:0] t;
        longint span;
        r  = $urandom_range(0, 99);
        s  = pick_index();
        l  = pick_index();
        tr = s * LAYERS + l;
        span = last_t[tr] - first_t[tr];
        if (r < 1)
            send_item(OP_CLEAR, s, l, $urandom, rand_vals(), 16'($urandom));
        else if (r < 45)
        begin
            // mostly rising times, some repeats and some out of order
            if (keys_in[tr] == 0)
                t = ($urandom_range(0, 9) == 0) ? $urandom
                                                : 32'(int'($urandom_range(0, 200)) - 100);
            else if ($urandom_range(0, 19) == 0)
                t = $urandom;
            else
                t = 32'(last_t[tr] + $urandom_range(0, 60));
            send_item(OP_APPEND, s, l, t, rand_vals(), 16'($urandom));
        end
        else if (r < 75)
        begin
            if (keys_in[tr] > 0 && span >= 0 && span < 100000 && $urandom_range(0, 9) != 0)
                t = 32'(first_t[tr] - 3 + $urandom_range(0, 32'(span) + 6));
            else
                t = $urandom;
            send_item(OP_QTIME, s, l, t, rand_vals(), 16'($urandom));
        end
        else
        begin
            t = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 65536));
            send_item(OP_QFRAC, s, l, t, rand_vals(), 16'($urandom));
        end
    endtask

    initial
    begin
        logic [NVAL-1:0][31:0] lo_v, hi_v, mix_v;
        lo_v  = {NVAL{32'h8000_0000}};
        hi_v  = {NVAL{32'h7fff_ffff}};
        foreach (keys_in[k]) keys_in[k] = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, missing tracks, fractions, unordered keys, clear
        send_item(OP_QTIME, 3'd0, 3'd0, 32'd0, lo_v, 16'h0000);
        send_item(OP_APPEND, 3'd0, 3'd0, 32'h8000_0000, lo_v, 16'h0000);
        send_item(OP_APPEND, 3'd0, 3'd0, 32'h7fff_ffff, hi_v, 16'hffff);
        send_item(OP_QTIME, 3'd0, 3'd0, 32'd0, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd0, 3'd0, 32'h7fff_ffff, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd0, 3'd0, 32'h8000_0000, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd0, 3'd0, 32'd0, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd0, 3'd0, 32'd65536, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd0, 3'd0, 32'hffff_ffff, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd0, 3'd0, 32'd32768, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd0, 3'd0, 32'd70000, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd0, 3'd1, 32'd0, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd7, 3'd7, 32'd0, lo_v, 16'h0000);
        mix_v = {32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000, 32'hffff_0000,
                 32'd0, 32'h1234_5678, 32'hedcb_a988};
        send_item(OP_APPEND, 3'd7, 3'd7, 32'd10, mix_v, 16'h5a5a);
        send_item(OP_APPEND, 3'd7, 3'd7, 32'd5, rand_vals(), 16'ha5a5);
        send_item(OP_APPEND, 3'd7, 3'd7, 32'd20, ~mix_v, 16'h00ff);
        send_item(OP_QTIME, 3'd7, 3'd7, 32'd7, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd7, 3'd7, 32'd15, lo_v, 16'h0000);
        send_item(OP_APPEND, 3'd7, 3'd7, 32'd20, hi_v, 16'hff00);
        send_item(OP_QTIME, 3'd7, 3'd7, 32'd20, lo_v, 16'h0000);
        send_item(OP_QFRAC, 3'd7, 3'd7, 32'd40000, lo_v, 16'h0000);
        send_item(OP_CLEAR, 3'd0, 3'd0, 32'd0, lo_v, 16'h0000);
        send_item(OP_QTIME, 3'd7, 3'd7, 32'd20, lo_v, 16'h0000);
        send_item(OP_APPEND, 3'd3, 3'd5, 32'd100, rand_vals(), 16'h1234);

        // long receiver hold-off while items keep coming
        hold_req = 1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if ($urandom_range(0, 49) == 0) tx_quiet = ~tx_quiet;
            // one burst that runs a track past full
            if (i == 300)
                for (int j = 0; j < FRAMES + 2; j++)
                    send_item(OP_APPEND, 3'd6, 3'd2, 32'(j * 7), rand_vals(), 16'($urandom));
            random_item();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0)
            $display("keyframe_linear_interpolator: match");
        else
            $display("keyframe_linear_interpolator: mismatch");
        $finish;
    end

endmodule
